@@ design/jqcu_pkg.sv @@
package jqcu_pkg;

   // Field widths of one item and one result
   localparam int OP_W     = 3;
   localparam int POS_W    = 8;
   localparam int TAG_W    = 32;
   localparam int PAGES_W  = 16;
   localparam int STATUS_W = 2;
   localparam int JPOS_W   = 7;

   // Default number of job slots
   localparam int DEPTH_DEFAULT = 64;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
   localparam logic [OP_W-1:0] OP_UPDATE  = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST    = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // One stored job
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [PAGES_W-1:0] pages;
   } job_type;

endpackage

@@ design/jqcu_req_if.sv @@
interface jqcu_req_if;
   import jqcu_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [POS_W-1:0]   position;
   logic [TAG_W-1:0]   document_tag;
   logic [PAGES_W-1:0] page_count;

   modport source (output valid, output operation, output position,
                   output document_tag, output page_count, input ready);
   modport sink   (input valid, input operation, input position,
                   input document_tag, input page_count, output ready);
endinterface

@@ design/jqcu_rsp_if.sv @@
interface jqcu_rsp_if;
   import jqcu_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [JPOS_W-1:0]   job_position;
   logic [TAG_W-1:0]    job_tag;
   logic [PAGES_W-1:0]  job_pages;
   logic                last;

   modport source (output valid, output status, output job_position,
                   output job_tag, output job_pages, output last, input ready);
   modport sink   (input valid, input status, input job_position,
                   input job_tag, input job_pages, input last, output ready);
endinterface

@@ design/job_queue_with_cancel_update.sv @@
// Job queue with cancel and update: a linear queue of DEPTH job slots held in a
// single-port-per-direction memory, driven by a small sequencer that makes at
// most one memory access per cycle. The block takes one item at a time and is
// not ready until every result of that item has been taken. Enqueue, update,
// error answers and unknown codes give a result registered in the decode step;
// dequeue reads the head slot and offers its job once the read is captured;
// cancel moves each job behind the cancelled one down by a read and a write
// through the memory port; list offers one result per pending job, each after
// a registered memory read. Slots freed by dequeue are reclaimed only when the
// queue drains; a cancel frees the last slot. No clearing pass runs after
// reset: the slot contents are never read before written.
module job_queue_with_cancel_update #(
   parameter int DEPTH = jqcu_pkg::DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   jqcu_req_if.sink  req,
   jqcu_rsp_if.source rsp
);
   import jqcu_pkg::*;

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SH_RD,
      S_SH_WR,
      S_LS_RD,
      S_CAPTURE,
      S_RESP
   } state_type;

   state_type           state_ff;
   logic [SLOT_W-1:0]   head_ff;
   logic [CNT_W-1:0]    tail_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic                list_ff;

   // Latched item
   logic [OP_W-1:0]     op_ff;
   logic [POS_W-1:0]    pos_ff;
   job_type             job_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [JPOS_W-1:0]   rsp_jpos_ff;
   job_type             rsp_job_ff;
   logic                rsp_last_ff;

   // Memory port
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   job_type             wr_data;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   job_type             rd_data;

   // Queue status
   logic                empty;
   logic                full;
   logic [CNT_W-1:0]    count;
   logic                pos_bad;
   logic [SLOT_W-1:0]   pos_slot;
   logic [SLOT_W-1:0]   list_slot;
   logic                list_end;

   assign empty     = CNT_W'(head_ff) >= tail_ff;
   assign full      = tail_ff == CNT_W'(DEPTH);
   assign count     = empty ? '0 : (tail_ff - CNT_W'(head_ff));
   assign pos_bad   = (pos_ff == '0) || (pos_ff > POS_W'(count));
   assign pos_slot  = head_ff + pos_ff[SLOT_W-1:0] - SLOT_W'(1);
   assign list_slot = head_ff + idx_ff[SLOT_W-1:0];
   assign list_end  = (idx_ff + CNT_W'(1)) == count;

   jqcu_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Drive the memory port from the current step
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_ff[SLOT_W-1:0];
      wr_data = job_ff;
      rd_en   = 1'b0;
      rd_addr = head_ff;
      unique case (state_ff)
         S_DECODE: begin
            if (op_ff == OP_ENQUEUE && !full) begin
               wr_en = 1'b1;
            end else if (op_ff == OP_UPDATE && !empty && !pos_bad) begin
               wr_en   = 1'b1;
               wr_addr = pos_slot;
            end else if (op_ff == OP_DEQUEUE && !empty) begin
               rd_en = 1'b1;
            end
         end
         S_SH_RD: begin
            rd_en   = (idx_ff + CNT_W'(1)) < tail_ff;
            rd_addr = idx_ff[SLOT_W-1:0] + SLOT_W'(1);
         end
         S_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[SLOT_W-1:0];
            wr_data = rd_data;
         end
         S_LS_RD: begin
            rd_en   = 1'b1;
            rd_addr = list_slot;
         end
         default: begin
         end
      endcase
   end

   assign req.ready        = state_ff == S_IDLE;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.job_position = rsp_jpos_ff;
   assign rsp.job_tag      = rsp_job_ff.tag;
   assign rsp.job_pages    = rsp_job_ff.pages;
   assign rsp.last         = rsp_last_ff;

   // Latch the item payload on acceptance
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff        <= req.operation;
         pos_ff       <= req.position;
         job_ff.tag   <= req.document_tag;
         job_ff.pages <= req.page_count;
      end
   end

   // Sequencer: state, queue pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         idx_ff       <= '0;
         list_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  state_ff <= S_DECODE;
               end
            end

            S_DECODE: begin
               // default answer: one result, nothing reported
               rsp_status_ff <= ST_OK;
               rsp_jpos_ff   <= '0;
               rsp_job_ff    <= '0;
               rsp_last_ff   <= 1'b1;
               list_ff       <= 1'b0;
               state_ff      <= S_RESP;
               rsp_valid_ff  <= 1'b1;
               priority if (op_ff == OP_ENQUEUE) begin
                  if (full) begin
                     rsp_status_ff <= ST_FULL;
                  end else begin
                     tail_ff <= tail_ff + CNT_W'(1);
                  end
               end else if (op_ff == OP_DEQUEUE || op_ff == OP_CANCEL ||
                            op_ff == OP_UPDATE || op_ff == OP_LIST) begin
                  if (empty) begin
                     rsp_status_ff <= ST_EMPTY;
                  end else if (op_ff == OP_DEQUEUE) begin
                     // advance head, reclaim all slots once drained
                     if ((CNT_W'(head_ff) + CNT_W'(1)) >= tail_ff) begin
                        head_ff <= '0;
                        tail_ff <= '0;
                     end else begin
                        head_ff <= head_ff + SLOT_W'(1);
                     end
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_CAPTURE;
                  end else if (op_ff == OP_LIST) begin
                     list_ff      <= 1'b1;
                     idx_ff       <= '0;
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_LS_RD;
                  end else if (pos_bad) begin
                     rsp_status_ff <= ST_BADPOS;
                  end else if (op_ff == OP_CANCEL) begin
                     idx_ff       <= CNT_W'(pos_slot);
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_SH_RD;
                  end
               end else begin
                  // unknown code: OK status, zero position and job, last set
               end
            end

            S_SH_RD: begin
               // move the next job down, or close the gap and finish
               if ((idx_ff + CNT_W'(1)) < tail_ff) begin
                  state_ff <= S_SH_WR;
               end else begin
                  if (CNT_W'(head_ff) >= (tail_ff - CNT_W'(1))) begin
                     head_ff <= '0;
                     tail_ff <= '0;
                  end else begin
                     tail_ff <= tail_ff - CNT_W'(1);
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end
            end

            S_SH_WR: begin
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= S_SH_RD;
            end

            S_LS_RD: begin
               state_ff <= S_CAPTURE;
            end

            S_CAPTURE: begin
               rsp_status_ff <= ST_OK;
               rsp_job_ff    <= rd_data;
               rsp_jpos_ff   <= list_ff ? (JPOS_W'(idx_ff) + JPOS_W'(1)) : '0;
               rsp_last_ff   <= list_ff ? list_end : 1'b1;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_RESP;
            end

            S_RESP: begin
               // hold the result until taken
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (list_ff && !rsp_last_ff) begin
                     idx_ff   <= idx_ff + CNT_W'(1);
                     state_ff <= S_LS_RD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/jqcu_store.sv @@
module jqcu_store #(
   parameter int DEPTH = jqcu_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  jqcu_pkg::job_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output jqcu_pkg::job_type        rd_data
);
   import jqcu_pkg::*;

   job_type job_store [DEPTH];
   job_type rd_data_ff;

   // Write one slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         job_store[wr_addr] <= wr_data;
      end
   end

   // Read one slot, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= job_store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
